[rtl/kmv_pkg.sv]
`default_nettype none
package kmv_pkg;

   localparam int unsigned HASH_W = 64;
   localparam int unsigned EST_W  = 32;
   localparam int unsigned CNT_W  = 9;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [HASH_W-1:0] hash_value;
   } req_type;

   typedef struct packed {
      logic              taken;
      logic              evicted;
      logic [CNT_W-1:0]  kept_count;
      logic [HASH_W-1:0] largest_kept;
      logic [EST_W-1:0]  distinct_estimate;
   } rsp_type;

   // divider start request and completion
   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [HASH_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [EST_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

[rtl/k_min_values_distinct_sketch.sv]
`default_nettype none
// Channel   Direction  Ports                          Moves
// req       in         req_valid/req_ready/req_data   insert or clear command
// rsp       out        rsp_valid/rsp_ready/rsp_data   one result per command
// csr       in         csr_valid/csr_ready/csr_wdata  sketch_size write
//
// Insert: scan (one memory read a cycle over the count entries kept before the
// insert), update, check the estimate, divide in the iterative divider when
// needed, then load the output register. Clear: check the estimate, then load
// the output register.
// Reset is synchronous; the value memory needs no clearing pass. A waiting
// result holds in the output register and the next result waits behind it.
module k_min_values_distinct_sketch #(
   parameter int unsigned MAX_KEPT = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire kmv_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output kmv_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [8:0]       csr_wdata
);
   import kmv_pkg::*;

   localparam int unsigned AW = $clog2(MAX_KEPT);
   localparam int unsigned CW = $clog2(MAX_KEPT + 1);
   localparam int unsigned KW = (CW > CNT_W) ? CW : CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_EST, ST_DIV, ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [HASH_W-1:0] val_ff, val_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [HASH_W-1:0] largest_ff, largest_in;
   logic [CNT_W-1:0]  sketch_ff, sketch_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     pidx_ff, pidx_in;
   logic              present_ff, present_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [HASH_W-1:0] max_oth_ff, max_oth_in;
   logic              taken_ff, taken_in;
   logic              evicted_ff, evicted_in;
   logic [EST_W-1:0]  est_ff, est_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              rd_en;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [HASH_W-1:0] rd_data;
   logic [KW-1:0]     sk_ext;
   logic [KW-1:0]     k_eff;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   kmv_mem #(.DEPTH(MAX_KEPT), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   kmv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // effective sketch size: zero acts as one, clamp to capacity
   always_comb begin
      sk_ext = KW'(sketch_ff);
      if (sk_ext == '0) begin
         k_eff = KW'(1);
      end else if (sk_ext > KW'(MAX_KEPT)) begin
         k_eff = KW'(MAX_KEPT);
      end else begin
         k_eff = sk_ext;
      end
   end

   assign rd_en     = (state_ff == ST_SCAN) && (idx_ff < count_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      val_in           = val_ff;
      count_in         = count_ff;
      largest_in       = largest_ff;
      sketch_in        = sketch_ff;
      idx_in           = idx_ff;
      pend_in          = 1'b0;
      pidx_in          = idx_ff;
      present_in       = present_ff;
      hit_in           = hit_ff;
      hit_idx_in       = hit_idx_ff;
      max_oth_in       = max_oth_ff;
      taken_in         = taken_ff;
      evicted_in       = evicted_ff;
      est_in           = est_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      wr_en            = 1'b0;
      wr_addr          = count_ff[AW-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = HASH_W'(count_ff - CW'(1));
      div_req.divisor  = largest_ff;

      if (csr_valid && csr_ready) begin
         sketch_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in     = req_data.hash_value;
               taken_in   = 1'b0;
               evicted_in = 1'b0;
               if (req_data.opcode == OP_CLEAR) begin
                  count_in   = '0;
                  largest_in = '0;
                  state_in   = ST_EST;
               end else begin
                  idx_in     = '0;
                  present_in = 1'b0;
                  hit_in     = 1'b0;
                  max_oth_in = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle, check the entry read last cycle
            pend_in = rd_en;
            if (rd_en) begin
               idx_in = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               if (rd_data == val_ff) begin
                  present_in = 1'b1;
               end
               if ((rd_data == largest_ff) && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pidx_ff[AW-1:0];
               end else if (rd_data > max_oth_ff) begin
                  max_oth_in = rd_data;
               end
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!present_ff) begin
               if (KW'(count_ff) < k_eff) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
                  if ((count_ff == '0) || (val_ff > largest_ff)) begin
                     largest_in = val_ff;
                  end
                  taken_in = 1'b1;
               end else if (val_ff < largest_ff) begin
                  // replace the largest entry, new largest from the rest
                  wr_en      = 1'b1;
                  wr_addr    = hit_idx_ff;
                  largest_in = (val_ff > max_oth_ff) ? val_ff : max_oth_ff;
                  taken_in   = 1'b1;
                  evicted_in = 1'b1;
               end
            end
            state_in = ST_EST;
         end
         ST_EST: begin
            if ((count_ff < CW'(2)) || (largest_ff == '0)) begin
               est_in   = '0;
               state_in = ST_FIN;
            end else if ((HASH_W'(count_ff - CW'(1)) << EST_W) >= largest_ff) begin
               est_in   = '1;
               state_in = ST_FIN;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               est_in   = div_rsp.quotient;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.taken             = taken_ff;
               rsp_data_in.evicted           = evicted_ff;
               rsp_data_in.kept_count        = CNT_W'(count_ff);
               rsp_data_in.largest_kept      = largest_ff;
               rsp_data_in.distinct_estimate = est_ff;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         largest_ff   <= '0;
         sketch_ff    <= CNT_W'(256);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         largest_ff   <= largest_in;
         sketch_ff    <= sketch_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      present_ff  <= present_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      max_oth_ff  <= max_oth_in;
      taken_ff    <= taken_in;
      evicted_ff  <= evicted_in;
      est_ff      <= est_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEPT))
      else $error("kept count above capacity");

   a_evict_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.evicted |-> rsp_data_ff.taken)
      else $error("eviction without take");

   a_est_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.largest_kept == '0)
      |-> (rsp_data_ff.distinct_estimate == '0))
      else $error("estimate with empty largest");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("command not started");

endmodule
`default_nettype wire

[rtl/kmv_mem.sv]
`default_nettype none
module kmv_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data
);
   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/kmv_div.sv]
`default_nettype none
module kmv_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kmv_pkg::div_req_type div_req,
   output kmv_pkg::div_rsp_type      div_rsp
);
   import kmv_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [5:0]        step_ff, step_in;
   logic [HASH_W-1:0] r_ff, r_in;
   logic [HASH_W-1:0] d_ff, d_in;
   logic [EST_W-1:0]  q_ff, q_in;
   logic [HASH_W-1:0] r_sh;
   logic              ge;

   // one restoring step a cycle, 64 steps
   always_comb begin
      r_sh    = {r_ff[HASH_W-2:0], 1'b0};
      ge      = r_ff[HASH_W-1] || (r_sh >= d_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         r_in    = div_req.dividend;
         d_in    = div_req.divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         r_in    = ge ? (r_sh - d_ff) : r_sh;
         q_in    = {q_ff[EST_W-2:0], ge};
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;
endmodule
`default_nettype wire
